>>> rtl/rwf_pkg.sv
// Package for the replay window filter: status codes, operations, defaults.
`timescale 1ns / 1ps
`default_nettype none
package rwf_pkg;
   localparam int TableDepthDefault    = 256;
   localparam int CleanupPeriodDefault = 100;
   localparam logic [15:0] WindowReset = 16'd300;

   typedef enum logic [1:0] {
      OP_VALIDATE = 2'd0,
      OP_LOOKUP   = 2'd1,
      OP_PURGE    = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_WINDOW   = 3'd1,
      ST_REPLAY   = 3'd2,
      ST_FULL     = 3'd3,
      ST_NOT_VAL  = 3'd4
   } status_type;
endpackage
`default_nettype wire

>>> rtl/replay_window_id_filter.sv
// Replay window filter: key/expiry table in memory, scanned by a sequencer.
// Lookup and validate scan the whole table before the result;
// a validate that triggers a cleanup adds a sweep of the table;
// purge sweeps the table; clear sweeps the valid bits.
// Throughput: one item at a time; the single memory read port sets the rate.
// Reset: synchronous; valid bits and count clear at once, window returns to 300.
`timescale 1ns / 1ps
`default_nettype none
module replay_window_id_filter #(
   parameter int TABLE_DEPTH    = rwf_pkg::TableDepthDefault,
   parameter int CLEANUP_PERIOD = rwf_pkg::CleanupPeriodDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_window_seconds,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_operation,
   input  wire logic [63:0] req_message_key,
   input  wire logic [31:0] req_message_time,
   input  wire logic [31:0] req_now_time,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_accepted,
   output logic [2:0]       rsp_status,
   output logic             rsp_key_seen,
   output logic [8:0]       rsp_removed_count,
   output logic [8:0]       rsp_entry_count
);
   import rwf_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int PW = (CLEANUP_PERIOD > 1) ? $clog2(CLEANUP_PERIOD) : 1;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,
      S_DEC   = 6'b000100,
      S_SWEEP = 6'b001000,
      S_CLR   = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   // storage
   logic [63:0] key_mem [TABLE_DEPTH];
   logic [32:0] exp_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;

   state_type state_ff, state_in;
   logic [15:0] win_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] cmod_ff, cmod_in;     // entry count modulo the cleanup period
   logic [1:0]  op_ff;
   logic [63:0] key_ff;
   logic [31:0] now_ff;
   logic        inwin_ff;
   logic [CW-1:0] idx_ff, idx_in;       // read address issued
   logic        rd_vld_ff;              // read data valid this cycle
   logic [AW-1:0] rd_idx_ff;            // slot of the read data
   logic [63:0] rd_key_ff;
   logic [32:0] rd_exp_ff;
   logic        hit_ff, hit_in;
   logic        free_ff, free_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic        acc_ff, acc_in;
   status_type  st_ff, st_in;
   logic        seen_ff, seen_in;
   logic        wr_en;
   logic        rd_en;
   logic        clr_en, del_en;
   logic [AW-1:0] del_idx;

   logic [32:0] upper, lower_s;
   logic [31:0] upper_sat, lower_sat;
   logic        inwin;

   always_comb begin
      upper     = {1'b0, req_now_time} + {17'd0, win_ff};
      upper_sat = upper[32] ? 32'hFFFF_FFFF : upper[31:0];
      lower_s   = {1'b0, req_now_time} - {17'd0, win_ff};
      lower_sat = lower_s[32] ? 32'd0 : lower_s[31:0];
      inwin     = (req_message_time >= lower_sat) && (req_message_time <= upper_sat);
   end

   assign csr_ready = (state_ff == S_IDLE) && !rsp_valid;
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid && !csr_valid;
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_accepted      = acc_ff;
   assign rsp_status        = st_ff;
   assign rsp_key_seen      = seen_ff;
   assign rsp_removed_count = 9'(rem_ff);
   assign rsp_entry_count   = 9'(count_ff);

   assign rd_en = ((state_ff == S_SCAN) || (state_ff == S_SWEEP))
                  && (idx_ff < CW'(TABLE_DEPTH));

   // memory read and write ports
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff <= key_mem[idx_ff[AW-1:0]];
         rd_exp_ff <= exp_mem[idx_ff[AW-1:0]];
      end
      rd_idx_ff <= idx_ff[AW-1:0];
      if (wr_en) begin
         key_mem[free_idx_ff] <= key_ff;
         exp_mem[free_idx_ff] <= {1'b0, now_ff} + {17'd0, win_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (wr_en) valid_ff[free_idx_ff] <= 1'b1;
         if (del_en) valid_ff[del_idx] <= 1'b0;
         if (clr_en) valid_ff[idx_ff[AW-1:0]] <= 1'b0;
      end
   end

   logic rd_live;
   assign rd_live = rd_vld_ff && valid_ff[rd_idx_ff];
   assign del_idx = rd_idx_ff;
   assign del_en  = (state_ff == S_SWEEP) && rd_live && (rd_exp_ff < {1'b0, now_ff});
   assign clr_en  = (state_ff == S_CLR) && (idx_ff < CW'(TABLE_DEPTH));

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      hit_in      = hit_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      rem_in      = rem_ff;
      acc_in      = acc_ff;
      st_in       = st_ff;
      seen_in     = seen_ff;
      count_in    = count_ff;
      cmod_in     = cmod_ff;
      wr_en       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               idx_in  = '0;
               hit_in  = 1'b0;
               free_in = 1'b0;
               rem_in  = '0;
               acc_in  = 1'b0;
               seen_in = 1'b0;
               st_in   = ST_NOT_VAL;
               unique case (op_type'(req_operation))
                  OP_VALIDATE, OP_LOOKUP: state_in = S_SCAN;
                  OP_PURGE:               state_in = S_SWEEP;
                  OP_CLEAR:               state_in = S_CLR;
                  default:                state_in = S_CLR;
               endcase
            end
         end
         S_SCAN: begin
            if (idx_ff < CW'(TABLE_DEPTH)) idx_in = idx_ff + 1'b1;
            if (rd_vld_ff) begin
               if (rd_live && rd_key_ff == key_ff) hit_in = 1'b1;
               if (!valid_ff[rd_idx_ff] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (rd_idx_ff == AW'(TABLE_DEPTH - 1)) state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (op_type'(op_ff) == OP_LOOKUP) begin
               seen_in  = hit_ff;
               state_in = S_RESP;
            end else if (!inwin_ff) begin
               st_in = ST_WINDOW; state_in = S_RESP;
            end else if (hit_ff) begin
               st_in = ST_REPLAY; state_in = S_RESP;
            end else if (count_ff >= CW'(TABLE_DEPTH) || !free_ff) begin
               st_in = ST_FULL; state_in = S_RESP;
            end else begin
               wr_en    = 1'b1;
               acc_in   = 1'b1;
               st_in    = ST_OK;
               count_in = count_ff + 1'b1;
               idx_in   = '0;
               if (cmod_ff == PW'(CLEANUP_PERIOD - 1)) begin
                  cmod_in  = '0;
                  state_in = S_SWEEP;
               end else begin
                  cmod_in  = cmod_ff + 1'b1;
                  state_in = S_RESP;
               end
            end
         end
         S_SWEEP: begin
            if (idx_ff < CW'(TABLE_DEPTH)) idx_in = idx_ff + 1'b1;
            if (del_en) begin
               rem_in  = rem_ff + 1'b1;
               cmod_in = (cmod_ff == '0) ? PW'(CLEANUP_PERIOD - 1) : cmod_ff - 1'b1;
            end
            if (rd_vld_ff && rd_idx_ff == AW'(TABLE_DEPTH - 1)) begin
               count_in = count_ff - (del_en ? rem_ff + 1'b1 : rem_ff);
               state_in = S_RESP;
            end
         end
         S_CLR: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == CW'(TABLE_DEPTH - 1)) begin
               count_in = '0;
               cmod_in  = '0;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         cmod_ff   <= '0;
         win_ff    <= WindowReset;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cmod_ff   <= cmod_in;
         rd_vld_ff <= rd_en;
         if (csr_valid && csr_ready) win_ff <= csr_window_seconds;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      hit_ff      <= hit_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      rem_ff      <= rem_in;
      acc_ff      <= acc_in;
      st_ff       <= st_in;
      seen_ff     <= seen_in;
      if (req_valid && req_ready) begin
         op_ff    <= req_operation;
         key_ff   <= req_message_key;
         now_ff   <= req_now_time;
         inwin_ff <= inwin;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH)) else $error("entry count above depth");
   a_accept_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_status == ST_OK) else $error("accept w/o ok");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready) else $error("ready while busy");
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !valid_ff[free_idx_ff]) else $error("insert over live slot");
endmodule
`default_nettype wire
